[rtl/hts_pkg.sv]
// Shared types, corner tables and split patterns for the hexahedron splitter.
`default_nettype none
package hts_pkg;

    localparam int unsigned NUM_CORNERS = 8;
    localparam int unsigned NUM_MINS    = 6;
    localparam int unsigned MAX_TETS    = 6;
    localparam int unsigned TET_WIDTH   = 32;

    typedef logic [2:0] t_corner;
    typedef logic [2:0] t_tet_idx;
    typedef logic [1:0] t_nbits;
    typedef logic [2:0] t_diag;

    typedef enum logic [1:0] {
        ROT_NONE = 2'd0,
        ROT_120  = 2'd1,
        ROT_240  = 2'd2
    } t_rot;

    localparam t_tet_idx TET_LAST_FIVE = 3'd4;
    localparam t_tet_idx TET_LAST_SIX  = 3'd5;

    localparam t_corner CORNER_PERM [NUM_CORNERS][NUM_CORNERS] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd1, 3'd0, 3'd4, 3'd5, 3'd2, 3'd3, 3'd7, 3'd6},
        '{3'd2, 3'd1, 3'd5, 3'd6, 3'd3, 3'd0, 3'd4, 3'd7},
        '{3'd3, 3'd0, 3'd1, 3'd2, 3'd7, 3'd4, 3'd5, 3'd6},
        '{3'd4, 3'd0, 3'd3, 3'd7, 3'd5, 3'd1, 3'd2, 3'd6},
        '{3'd5, 3'd1, 3'd0, 3'd4, 3'd6, 3'd2, 3'd3, 3'd7},
        '{3'd6, 3'd2, 3'd1, 3'd5, 3'd7, 3'd3, 3'd0, 3'd4},
        '{3'd7, 3'd3, 3'd2, 3'd6, 3'd4, 3'd0, 3'd1, 3'd5}
    };

    localparam t_rot ROT_OF_BITS [NUM_CORNERS] = '{
        ROT_NONE, ROT_120, ROT_240, ROT_NONE, ROT_NONE, ROT_240, ROT_120, ROT_NONE
    };

    localparam t_corner SPLIT_TAB [4][MAX_TETS][4] = '{
        '{ '{3'd0, 3'd1, 3'd2, 3'd5}, '{3'd0, 3'd2, 3'd7, 3'd5}, '{3'd0, 3'd2, 3'd3, 3'd7},
           '{3'd0, 3'd5, 3'd7, 3'd4}, '{3'd2, 3'd7, 3'd5, 3'd6}, '{3'd0, 3'd0, 3'd0, 3'd0} },
        '{ '{3'd0, 3'd5, 3'd7, 3'd4}, '{3'd0, 3'd1, 3'd7, 3'd5}, '{3'd1, 3'd6, 3'd7, 3'd5},
           '{3'd0, 3'd7, 3'd2, 3'd3}, '{3'd0, 3'd7, 3'd1, 3'd2}, '{3'd1, 3'd7, 3'd6, 3'd2} },
        '{ '{3'd0, 3'd4, 3'd5, 3'd6}, '{3'd0, 3'd3, 3'd7, 3'd6}, '{3'd0, 3'd7, 3'd4, 3'd6},
           '{3'd0, 3'd1, 3'd2, 3'd5}, '{3'd0, 3'd3, 3'd6, 3'd2}, '{3'd0, 3'd6, 3'd5, 3'd2} },
        '{ '{3'd0, 3'd2, 3'd3, 3'd6}, '{3'd0, 3'd3, 3'd7, 3'd6}, '{3'd0, 3'd7, 3'd4, 3'd6},
           '{3'd0, 3'd5, 3'd6, 3'd4}, '{3'd1, 3'd5, 3'd6, 3'd0}, '{3'd1, 3'd6, 3'd2, 3'd0} }
    };

endpackage
`default_nettype wire

[rtl/hts_lane.sv]
// One minimum-search lane: flags its corner as the first smallest index.
`default_nettype none
module hts_lane #(
    parameter int unsigned W    = 32,
    parameter int unsigned LANE = 0
) (
    input  logic [W-1:0] i_v [hts_pkg::NUM_CORNERS],
    output logic         o_win
);
    import hts_pkg::*;

    always_comb begin
        o_win = 1'b1;
        for (int j = 0; j < NUM_CORNERS; j++) begin
            if (j < int'(LANE)) begin
                if (!(i_v[LANE] < i_v[j])) begin
                    o_win = 1'b0;
                end
            end else if (j > int'(LANE)) begin
                if (i_v[j] < i_v[LANE]) begin
                    o_win = 1'b0;
                end
            end
        end
    end

endmodule
`default_nettype wire

[rtl/hts_merge.sv]
// Merges the one-hot lane flags into the index of the smallest corner.
`default_nettype none
module hts_merge (
    input  logic [hts_pkg::NUM_CORNERS-1:0] i_win,
    output hts_pkg::t_corner                o_corner
);
    import hts_pkg::*;

    always_comb begin
        o_corner = '0;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            if (i_win[k]) begin
                o_corner = o_corner | t_corner'(k);
            end
        end
    end

endmodule
`default_nettype wire

[rtl/hts_emit.sv]
// Output stage: holds one split hexahedron and emits its tetrahedra in order.
`default_nettype none
module hts_emit #(
    parameter int unsigned W = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [W-1:0]                  i_vq [hts_pkg::NUM_CORNERS],
    input  hts_pkg::t_nbits               i_n,
    output logic                          o_ready,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [hts_pkg::TET_WIDTH-1:0] o_tet_a,
    output logic [hts_pkg::TET_WIDTH-1:0] o_tet_b,
    output logic [hts_pkg::TET_WIDTH-1:0] o_tet_c,
    output logic [hts_pkg::TET_WIDTH-1:0] o_tet_d,
    output logic                          o_last_of_run
);
    import hts_pkg::*;

    logic         r_vld;
    t_tet_idx     r_k;
    logic [W-1:0] r_vq [NUM_CORNERS];
    t_nbits       r_n;

    t_tet_idx     w_last_k;
    logic         w_acc;
    logic         w_end;

    assign w_last_k = (r_n == 2'd0) ? TET_LAST_FIVE : TET_LAST_SIX;
    assign w_acc    = r_vld && !i_stall;
    assign w_end    = w_acc && (r_k == w_last_k);
    assign o_ready  = !r_vld || w_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_k   <= '0;
        end else if (i_load) begin
            r_vld <= 1'b1;
            r_k   <= '0;
        end else if (w_end) begin
            r_vld <= 1'b0;
            r_k   <= '0;
        end else if (w_acc) begin
            r_k   <= r_k + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_vq <= i_vq;
            r_n  <= i_n;
        end
    end

    assign o_valid       = r_vld;
    assign o_last_of_run = (r_k == w_last_k);
    assign o_tet_a       = TET_WIDTH'(r_vq[SPLIT_TAB[r_n][r_k][0]]);
    assign o_tet_b       = TET_WIDTH'(r_vq[SPLIT_TAB[r_n][r_k][1]]);
    assign o_tet_c       = TET_WIDTH'(r_vq[SPLIT_TAB[r_n][r_k][2]]);
    assign o_tet_d       = TET_WIDTH'(r_vq[SPLIT_TAB[r_n][r_k][3]]);

endmodule
`default_nettype wire

[rtl/hexahedron_to_tetrahedra_split.sv]
// Top level: splits one hexahedron item into five or six tetrahedron items.
// Output: five tetrahedra per hexahedron (no diagonal bit) or six, all through
// the single result port of the output stage; a new hexahedron loads in the cycle
// the last tetrahedron of the previous one is taken.
// Reset: synchronous, active low; clears the stage valid flags and the item counter.
`default_nettype none
module hexahedron_to_tetrahedra_split #(
    parameter int unsigned INDEX_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [INDEX_WIDTH-1:0]        i_vertex_0,
    input  logic [INDEX_WIDTH-1:0]        i_vertex_1,
    input  logic [INDEX_WIDTH-1:0]        i_vertex_2,
    input  logic [INDEX_WIDTH-1:0]        i_vertex_3,
    input  logic [INDEX_WIDTH-1:0]        i_vertex_4,
    input  logic [INDEX_WIDTH-1:0]        i_vertex_5,
    input  logic [INDEX_WIDTH-1:0]        i_vertex_6,
    input  logic [INDEX_WIDTH-1:0]        i_vertex_7,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [hts_pkg::TET_WIDTH-1:0] o_tet_a,
    output logic [hts_pkg::TET_WIDTH-1:0] o_tet_b,
    output logic [hts_pkg::TET_WIDTH-1:0] o_tet_c,
    output logic [hts_pkg::TET_WIDTH-1:0] o_tet_d,
    output logic                          o_last_of_run
);
    import hts_pkg::*;

    localparam int unsigned W = INDEX_WIDTH;

    // stage 1: input register, lane search
    logic         r1_vld;
    logic [W-1:0] r1_v [NUM_CORNERS];
    // stage 2: smallest corner found, permute and take pair minima
    logic         r2_vld;
    logic [W-1:0] r2_v [NUM_CORNERS];
    t_corner      r2_r;
    // stage 3: diagonal bits, rotation
    logic         r3_vld;
    logic [W-1:0] r3_v [NUM_CORNERS];
    t_corner      r3_p [NUM_CORNERS];
    logic [W-1:0] r3_min [NUM_MINS];

    logic [W-1:0]           w_in_v [NUM_CORNERS];
    logic [NUM_CORNERS-1:0] w_win;
    t_corner                w_r;
    t_corner                w_p [NUM_CORNERS];
    logic [W-1:0]           w_vp [NUM_CORNERS];
    logic [W-1:0]           w_min [NUM_MINS];
    t_diag                  w_bits;
    t_nbits                 w_n;
    t_rot                   w_rot;
    t_corner                w_pr [NUM_CORNERS];
    logic [W-1:0]           w_vq [NUM_CORNERS];

    logic w_in_acc;
    logic w_rdy1;
    logic w_rdy2;
    logic w_rdy3;
    logic w_emit_rdy;
    logic w_emit_load;

    assign w_in_v[0] = i_vertex_0;
    assign w_in_v[1] = i_vertex_1;
    assign w_in_v[2] = i_vertex_2;
    assign w_in_v[3] = i_vertex_3;
    assign w_in_v[4] = i_vertex_4;
    assign w_in_v[5] = i_vertex_5;
    assign w_in_v[6] = i_vertex_6;
    assign w_in_v[7] = i_vertex_7;

    assign w_rdy3      = !r3_vld || w_emit_rdy;
    assign w_rdy2      = !r2_vld || w_rdy3;
    assign w_rdy1      = !r1_vld || w_rdy2;
    assign o_stall     = !w_rdy1;
    assign w_in_acc    = i_valid && w_rdy1;
    assign w_emit_load = r3_vld && w_emit_rdy;

    genvar g;
    generate
        for (g = 0; g < NUM_CORNERS; g++) begin : g_lane
            hts_lane #(
                .W    (W),
                .LANE (g)
            ) u_lane (
                .i_v   (r1_v),
                .o_win (w_win[g])
            );
        end
    endgenerate

    hts_merge u_merge (
        .i_win    (w_win),
        .o_corner (w_r)
    );

    always_comb begin
        for (int k = 0; k < NUM_CORNERS; k++) begin
            w_p[k]  = CORNER_PERM[r2_r][k];
            w_vp[k] = r2_v[w_p[k]];
        end
        w_min[0] = (w_vp[1] < w_vp[6]) ? w_vp[1] : w_vp[6];
        w_min[1] = (w_vp[2] < w_vp[5]) ? w_vp[2] : w_vp[5];
        w_min[2] = (w_vp[3] < w_vp[6]) ? w_vp[3] : w_vp[6];
        w_min[3] = (w_vp[2] < w_vp[7]) ? w_vp[2] : w_vp[7];
        w_min[4] = (w_vp[4] < w_vp[6]) ? w_vp[4] : w_vp[6];
        w_min[5] = (w_vp[5] < w_vp[7]) ? w_vp[5] : w_vp[7];
    end

    always_comb begin
        w_bits[2] = r3_min[0] < r3_min[1];
        w_bits[1] = r3_min[2] < r3_min[3];
        w_bits[0] = r3_min[4] < r3_min[5];
        w_n   = {1'b0, w_bits[0]} + {1'b0, w_bits[1]} + {1'b0, w_bits[2]};
        w_rot = ROT_OF_BITS[w_bits];
        w_pr  = r3_p;
        case (w_rot)
            ROT_120: begin
                w_pr[1] = r3_p[4];
                w_pr[4] = r3_p[3];
                w_pr[3] = r3_p[1];
                w_pr[5] = r3_p[7];
                w_pr[7] = r3_p[2];
                w_pr[2] = r3_p[5];
            end
            ROT_240: begin
                w_pr[1] = r3_p[3];
                w_pr[3] = r3_p[4];
                w_pr[4] = r3_p[1];
                w_pr[5] = r3_p[2];
                w_pr[2] = r3_p[7];
                w_pr[7] = r3_p[5];
            end
            default: begin
                w_pr = r3_p;
            end
        endcase
        for (int k = 0; k < NUM_CORNERS; k++) begin
            w_vq[k] = r3_v[w_pr[k]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r1_vld <= i_valid;
            end
            if (w_rdy2) begin
                r2_vld <= r1_vld;
            end
            if (w_rdy3) begin
                r3_vld <= r2_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r1_v <= w_in_v;
        end
        if (w_rdy2 && r1_vld) begin
            r2_v <= r1_v;
            r2_r <= w_r;
        end
        if (w_rdy3 && r2_vld) begin
            r3_v   <= r2_v;
            r3_p   <= w_p;
            r3_min <= w_min;
        end
    end

    hts_emit #(
        .W (W)
    ) u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_emit_load),
        .i_vq          (w_vq),
        .i_n           (w_n),
        .o_ready       (w_emit_rdy),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_tet_a       (o_tet_a),
        .o_tet_b       (o_tet_b),
        .o_tet_c       (o_tet_c),
        .o_tet_d       (o_tet_d),
        .o_last_of_run (o_last_of_run)
    );

    a_lane_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_vld |-> $onehot(w_win))
        else $error("lane search did not find exactly one smallest corner");

    a_run_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_of_run) |=> o_valid)
        else $error("tetrahedron run ended before its last item");

    a_no_short_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_of_run) |=> !(o_valid && o_last_of_run))
        else $error("last item followed directly by another last item");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r1_vld && r2_vld && r3_vld && !w_emit_rdy))
        else $error("input stalled while the pipeline has room");

endmodule
`default_nettype wire

[test/hexahedron_to_tetrahedra_split_chk.sv]
// Checker for the hexahedron splitter: predicts the tetrahedra of each hexahedron and compares.
module hexahedron_to_tetrahedra_split_chk (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  logic [7:0][31:0] i_hex,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic [31:0]      i_tet_a,
    input  logic [31:0]      i_tet_b,
    input  logic [31:0]      i_tet_c,
    input  logic [31:0]      i_tet_d,
    input  logic             i_last,
    output int               o_err_count,
    output int               o_due
);
    timeunit 1ns;
    timeprecision 1ps;
    import hts_pkg::*;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic        last;
    } t_tet;

    // corner renumbering, row = corner holding the smallest index
    localparam logic [0:7][0:7][2:0] CORNER_MAP = {
        {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
        {3'd1, 3'd0, 3'd4, 3'd5, 3'd2, 3'd3, 3'd7, 3'd6},
        {3'd2, 3'd1, 3'd5, 3'd6, 3'd3, 3'd0, 3'd4, 3'd7},
        {3'd3, 3'd0, 3'd1, 3'd2, 3'd7, 3'd4, 3'd5, 3'd6},
        {3'd4, 3'd0, 3'd3, 3'd7, 3'd5, 3'd1, 3'd2, 3'd6},
        {3'd5, 3'd1, 3'd0, 3'd4, 3'd6, 3'd2, 3'd3, 3'd7},
        {3'd6, 3'd2, 3'd1, 3'd5, 3'd7, 3'd3, 3'd0, 3'd4},
        {3'd7, 3'd3, 3'd2, 3'd6, 3'd4, 3'd0, 3'd1, 3'd5}
    };

    localparam logic [0:7][1:0] ROT_BY_DIAG = {
        ROT_NONE, ROT_120, ROT_240, ROT_NONE, ROT_NONE, ROT_240, ROT_120, ROT_NONE
    };

    // local corners of each tetrahedron, by number of set diagonal bits
    localparam logic [0:3][0:5][0:3][2:0] TET_PATTERN = {
        {{3'd0, 3'd1, 3'd2, 3'd5}, {3'd0, 3'd2, 3'd7, 3'd5}, {3'd0, 3'd2, 3'd3, 3'd7},
         {3'd0, 3'd5, 3'd7, 3'd4}, {3'd2, 3'd7, 3'd5, 3'd6}, {3'd0, 3'd0, 3'd0, 3'd0}},
        {{3'd0, 3'd5, 3'd7, 3'd4}, {3'd0, 3'd1, 3'd7, 3'd5}, {3'd1, 3'd6, 3'd7, 3'd5},
         {3'd0, 3'd7, 3'd2, 3'd3}, {3'd0, 3'd7, 3'd1, 3'd2}, {3'd1, 3'd7, 3'd6, 3'd2}},
        {{3'd0, 3'd4, 3'd5, 3'd6}, {3'd0, 3'd3, 3'd7, 3'd6}, {3'd0, 3'd7, 3'd4, 3'd6},
         {3'd0, 3'd1, 3'd2, 3'd5}, {3'd0, 3'd3, 3'd6, 3'd2}, {3'd0, 3'd6, 3'd5, 3'd2}},
        {{3'd0, 3'd2, 3'd3, 3'd6}, {3'd0, 3'd3, 3'd7, 3'd6}, {3'd0, 3'd7, 3'd4, 3'd6},
         {3'd0, 3'd5, 3'd6, 3'd4}, {3'd1, 3'd5, 3'd6, 3'd0}, {3'd1, 3'd6, 3'd2, 3'd0}}
    };

    t_tet tets_due[$];
    int   errors = 0;

    assign o_err_count = errors;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns chk: %s got %h want %h", $time, what, got, want);
        errors++;
    endtask

    function automatic logic [31:0] min_of(input logic [31:0] x, input logic [31:0] y);
        return (x < y) ? x : y;
    endfunction

    task automatic split_hexahedron(input logic [7:0][31:0] vx);
        logic [2:0]  pm [8];
        logic [2:0]  root;
        logic [2:0]  tmp;
        logic [2:0]  diag;
        t_rot        rot;
        int unsigned nset;
        int unsigned count;
        t_tet        tet;
        root = 3'd0;
        for (int k = 1; k < 8; k++)
            if (vx[k] < vx[root])
                root = k[2:0];
        for (int k = 0; k < 8; k++)
            pm[k] = CORNER_MAP[root][k];
        diag = 3'b000;
        nset = 0;
        if (min_of(vx[pm[1]], vx[pm[6]]) < min_of(vx[pm[2]], vx[pm[5]])) begin
            diag[2] = 1'b1;
            nset++;
        end
        if (min_of(vx[pm[3]], vx[pm[6]]) < min_of(vx[pm[2]], vx[pm[7]])) begin
            diag[1] = 1'b1;
            nset++;
        end
        if (min_of(vx[pm[4]], vx[pm[6]]) < min_of(vx[pm[5]], vx[pm[7]])) begin
            diag[0] = 1'b1;
            nset++;
        end
        rot = t_rot'(ROT_BY_DIAG[diag]);
        case (rot)
            ROT_120: begin
                tmp = pm[1]; pm[1] = pm[4]; pm[4] = pm[3]; pm[3] = tmp;
                tmp = pm[5]; pm[5] = pm[7]; pm[7] = pm[2]; pm[2] = tmp;
            end
            ROT_240: begin
                tmp = pm[1]; pm[1] = pm[3]; pm[3] = pm[4]; pm[4] = tmp;
                tmp = pm[5]; pm[5] = pm[2]; pm[2] = pm[7]; pm[7] = tmp;
            end
            default: ;
        endcase
        count = (nset == 0) ? 5 : 6;
        for (int k = 0; k < count; k++) begin
            tet.a    = vx[pm[TET_PATTERN[nset][k][0]]];
            tet.b    = vx[pm[TET_PATTERN[nset][k][1]]];
            tet.c    = vx[pm[TET_PATTERN[nset][k][2]]];
            tet.d    = vx[pm[TET_PATTERN[nset][k][3]]];
            tet.last = (k == count - 1);
            tets_due.insert(tets_due.size(), tet);
        end
    endtask

    always @(posedge i_clk) begin
        t_tet want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall)
                split_hexahedron(i_hex);
            if (i_out_valid && !i_out_stall) begin
                if (tets_due.size() == 0) begin
                    report_mismatch("tetrahedron with none due, tet_a", i_tet_a, '0);
                end else begin
                    want = tets_due.pop_front();
                    if (i_tet_a !== want.a)
                        report_mismatch("tet_a", i_tet_a, want.a);
                    if (i_tet_b !== want.b)
                        report_mismatch("tet_b", i_tet_b, want.b);
                    if (i_tet_c !== want.c)
                        report_mismatch("tet_c", i_tet_c, want.c);
                    if (i_tet_d !== want.d)
                        report_mismatch("tet_d", i_tet_d, want.d);
                    if (i_last !== want.last)
                        report_mismatch("last_of_run", {31'd0, i_last}, {31'd0, want.last});
                end
            end
        end
        o_due <= tets_due.size();
    end

endmodule

[test/hexahedron_to_tetrahedra_split_tb.sv]
// Testbench top for the hexahedron splitter: clock, reset, stimulus, stalls and verdict.
module hexahedron_to_tetrahedra_split_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hts_pkg::*;

    localparam int unsigned RANDOM_HEXES = 370;
    localparam int unsigned STUCK_LIMIT  = 2000;
    localparam int unsigned TAIL_CYCLES  = 12;

    typedef logic [7:0][31:0] t_hexv;

    typedef enum int unsigned {
        MIX_FULL,
        MIX_TINY,
        MIX_TOP,
        MIX_NEAR
    } t_mix;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  out_stall = 1'b0;
    logic  quiet     = 1'b0;
    t_hexv hex       = '0;

    logic                 in_stall;
    logic                 out_valid;
    logic                 out_last;
    logic [TET_WIDTH-1:0] tet_a;
    logic [TET_WIDTH-1:0] tet_b;
    logic [TET_WIDTH-1:0] tet_c;
    logic [TET_WIDTH-1:0] tet_d;
    int                   err_count;
    int                   due_count;
    int unsigned          stuck_cycles = 0;

    always #5 clk = ~clk;

    hexahedron_to_tetrahedra_split #(
        .INDEX_WIDTH(32)
    ) u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_stall      (in_stall),
        .i_vertex_0   (hex[0]),
        .i_vertex_1   (hex[1]),
        .i_vertex_2   (hex[2]),
        .i_vertex_3   (hex[3]),
        .i_vertex_4   (hex[4]),
        .i_vertex_5   (hex[5]),
        .i_vertex_6   (hex[6]),
        .i_vertex_7   (hex[7]),
        .o_valid      (out_valid),
        .i_stall      (out_stall),
        .o_tet_a      (tet_a),
        .o_tet_b      (tet_b),
        .o_tet_c      (tet_c),
        .o_tet_d      (tet_d),
        .o_last_of_run(out_last)
    );

    hexahedron_to_tetrahedra_split_chk u_chk (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_stall (in_stall),
        .i_hex      (hex),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_tet_a    (tet_a),
        .i_tet_b    (tet_b),
        .i_tet_c    (tet_c),
        .i_tet_d    (tet_d),
        .i_last     (out_last),
        .o_err_count(err_count),
        .o_due      (due_count)
    );

    always @(negedge clk) begin
        out_stall = quiet ? 1'b0 : ($urandom_range(0, 99) < 12);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial begin
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_hex(input t_hexv h);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 99) < 12) begin
            in_valid = 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
        end
        hex      = h;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    function automatic t_hexv random_hex();
        t_hexv       h;
        t_mix        mix;
        logic [31:0] base;
        mix  = t_mix'($urandom_range(0, 3));
        base = $urandom();
        for (int k = 0; k < 8; k++) begin
            case (mix)
                MIX_FULL: h[k] = $urandom();
                MIX_TINY: h[k] = $urandom_range(0, 7);
                MIX_TOP:  h[k] = 32'hFFFF_FFF8 | $urandom_range(0, 7);
                default:  h[k] = base + $urandom_range(0, 15);
            endcase
        end
        return h;
    endfunction

    initial begin
        t_hexv h;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_hex('0);
        send_hex('1);
        send_hex({32'd7, 32'd6, 32'd5, 32'd4, 32'd3, 32'd2, 32'd1, 32'd0});
        send_hex({32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7});
        send_hex({8{32'h5555_5555}});
        send_hex({4{32'hAAAA_AAAA, 32'h5555_5555}});
        send_hex({4{32'h5555_5555, 32'hAAAA_AAAA}});
        // tie for the smallest index: lowest corner wins
        send_hex({32'd9, 32'd2, 32'd9, 32'd9, 32'd9, 32'd2, 32'd9, 32'd9});
        send_hex({32'd3, 32'd3, 32'd5, 32'd5, 32'd1, 32'd1, 32'd5, 32'd5});
        send_hex({32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1});
        // smallest index at each corner in turn
        for (int k = 0; k < 8; k++) begin
            for (int j = 0; j < 8; j++)
                h[j] = $urandom() | 32'h8000_0000;
            h[k] = $urandom_range(0, 1000);
            send_hex(h);
        end

        for (int n = 0; n < RANDOM_HEXES; n++) begin
            quiet = (n >= 150 && n < 230);
            send_hex(random_hex());
        end
        quiet    = 1'b0;
        in_valid = 1'b0;

        while (due_count != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (err_count == 0 && due_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
rtl/hts_pkg.sv
rtl/hts_lane.sv
rtl/hts_merge.sv
rtl/hts_emit.sv
rtl/hexahedron_to_tetrahedra_split.sv
test/hexahedron_to_tetrahedra_split_chk.sv
test/hexahedron_to_tetrahedra_split_tb.sv
